### design/dolr_pkg.sv
package dolr_pkg;

   // decay factor is unsigned q0.16
   localparam int DECAY_BITS  = 16;
   localparam int CSR_BITS    = 16;
   // width of determinant and numerators
   localparam int NUM_BITS    = 64;
   // slope and intercept are q16.16
   localparam int QUO_BITS    = 32;
   localparam int SLOPE_SHIFT = 16;

   typedef logic [0:0] csr_index_type;
   localparam csr_index_type REG_DECAY  = 1'b0;
   localparam csr_index_type REG_THRESH = 1'b1;

   typedef logic [2:0] sum_sel_type;
   localparam sum_sel_type SEL_W   = 3'd0;
   localparam sum_sel_type SEL_X   = 3'd1;
   localparam sum_sel_type SEL_Y   = 3'd2;
   localparam sum_sel_type SEL_XX  = 3'd3;
   localparam sum_sel_type SEL_XY  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECAY,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_MUL4,
      ST_DIV,
      ST_OUT
   } back_state_type;

endpackage

### design/dolr_fifo.sv
module dolr_fifo
   import dolr_pkg::*;
#(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == (AW+1)'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wr_data;
      end
   end

endmodule

### design/dolr_front.sv
module dolr_front
   import dolr_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int IN_BITS     = 32
) (
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [IN_BITS-1:0]       req_tdata,
   input  logic                     q_full,
   output logic                     q_push,
   // x, y, x*x, x*y from lowest bits up
   output logic [6*SAMPLE_BITS-1:0] q_data
);

   logic signed [SAMPLE_BITS-1:0]   x, y;
   logic signed [2*SAMPLE_BITS-1:0] xx, xy;

   assign x  = $signed(req_tdata[SAMPLE_BITS-1:0]);
   assign y  = $signed(req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
   assign xx = x * x;
   assign xy = x * y;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;
   assign q_data     = {xy, xx, y, x};

endmodule

### design/dolr_div.sv
module dolr_div
   import dolr_pkg::*;
#(
   parameter int FRAC = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [NUM_BITS-1:0] num,
   input  logic        [NUM_BITS-1:0] den,
   output logic                       done,
   output logic signed [QUO_BITS-1:0] quo
);

   localparam int RW = NUM_BITS + QUO_BITS;
   localparam int CW = $clog2(QUO_BITS);

   logic [RW-1:0]       rem_ff, rem_in, dsh_ff, dsh_in;
   logic [QUO_BITS-1:0] q_ff, q_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic                neg_ff, neg_in, sat_ff, sat_in;
   logic [NUM_BITS-1:0] mag;
   logic                ge;

   assign mag = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
   assign ge  = (rem_ff >= dsh_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      sat_in  = sat_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = RW'(mag) << FRAC;
         dsh_in  = RW'(den) << (QUO_BITS-1);
         q_in    = '0;
         cnt_in  = CW'(QUO_BITS-1);
         busy_in = 1'b1;
         neg_in  = num[NUM_BITS-1];
         sat_in  = 1'b0;
      end else if (busy_ff) begin
         q_in   = {q_ff[QUO_BITS-2:0], ge};
         rem_in = ge ? rem_ff - dsh_ff : rem_ff;
         dsh_in = dsh_ff >> 1;
         // a top bit means the quotient does not fit
         if (cnt_ff == CW'(QUO_BITS-1) && ge) begin
            sat_in = 1'b1;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      sat_ff <= sat_in;
   end

   always_comb begin
      if (sat_ff) begin
         quo = neg_ff ? {1'b1, {(QUO_BITS-1){1'b0}}} : {1'b0, {(QUO_BITS-1){1'b1}}};
      end else begin
         quo = neg_ff ? $signed(-q_ff) : $signed(q_ff);
      end
   end

   assign done = done_ff;

endmodule

### design/dolr_back.sv
module dolr_back
   import dolr_pkg::*;
#(
   parameter int SAMPLE_BITS         = 16,
   parameter int EXTRA_FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  logic [6*SAMPLE_BITS-1:0] q_data,
   output logic                     q_pop,
   input  logic [DECAY_BITS-1:0]    decay_coef,
   input  logic [CSR_BITS-1:0]      det_threshold,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [QUO_BITS-1:0]      slope,
   output logic [QUO_BITS-1:0]      intercept,
   output logic                     refreshed
);

   localparam int SB         = SAMPLE_BITS;
   localparam int E          = EXTRA_FRACTION_BITS;
   localparam int HALF_E     = E / 2;
   localparam int W_BITS     = E + 4;
   localparam int SX_BITS    = SB + E + 4;
   localparam int SXX_BITS   = 2 * SB + E + 4;
   localparam int ACC_BITS   = SXX_BITS + 2;
   localparam int SXS_BITS   = SX_BITS - HALF_E;
   localparam int SXXS_BITS  = SXX_BITS - E;
   localparam int MAGH_BITS  = SXX_BITS - DECAY_BITS;
   localparam int ICPT_SHIFT = SLOPE_SHIFT + HALF_E - SB / 2;

   back_state_type state_ff, state_in;

   logic [W_BITS-1:0]          weight_ff;
   logic signed [SX_BITS-1:0]  sum_x_ff, sum_y_ff;
   logic signed [SXX_BITS-1:0] sum_xx_ff, sum_xy_ff;
   logic signed [QUO_BITS-1:0] slope_hold_ff, icpt_hold_ff;

   logic signed [SB-1:0]       x_ff, y_ff;
   logic signed [2*SB-1:0]     xx_ff, xy_ff;
   sum_sel_type                sel_ff;

   logic signed [NUM_BITS-1:0] pa_ff, pb_ff, det_ff, num1_ff;
   logic                       fresh_ff;

   logic                       rsp_valid_ff;
   logic [QUO_BITS-1:0]        rsp_slope_ff, rsp_icpt_ff;
   logic                       rsp_fresh_ff;

   logic                       det_gt, div_start, out_load, div_done, div2_done;
   logic signed [QUO_BITS-1:0] slope_q, icpt_q;
   logic signed [NUM_BITS-1:0] num2;

   // decay and accumulate datapath
   logic signed [SXX_BITS-1:0] cur;
   logic signed [ACC_BITS-1:0] term, dec, acc, acc_sat;
   logic [SXX_BITS-1:0]        mag, r;
   logic [MAGH_BITS+DECAY_BITS-1:0] prod_hi;
   logic [2*DECAY_BITS-1:0]    prod_lo;

   logic signed [SXS_BITS-1:0]  sx, sy;
   logic signed [SXXS_BITS-1:0] sxx, sxy;
   logic signed [W_BITS:0]      ws;

   function automatic logic signed [ACC_BITS-1:0] sat_to(
      input logic signed [ACC_BITS-1:0] v,
      input int                         n
   );
      logic signed [ACC_BITS-1:0] hi, lo;
      hi = (ACC_BITS'(1) <<< (n - 1)) - ACC_BITS'(1);
      lo = ~hi;
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   always_comb begin
      case (sel_ff)
         SEL_W: begin
            cur  = SXX_BITS'($signed({1'b0, weight_ff}));
            term = ACC_BITS'(1) <<< E;
         end
         SEL_X: begin
            cur  = SXX_BITS'(sum_x_ff);
            term = ACC_BITS'(x_ff) <<< E;
         end
         SEL_Y: begin
            cur  = SXX_BITS'(sum_y_ff);
            term = ACC_BITS'(y_ff) <<< E;
         end
         SEL_XX: begin
            cur  = sum_xx_ff;
            term = ACC_BITS'(xx_ff) <<< E;
         end
         SEL_XY: begin
            cur  = sum_xy_ff;
            term = ACC_BITS'(xy_ff) <<< E;
         end
         default: begin
            cur  = '0;
            term = '0;
         end
      endcase
   end

   // magnitude scaled by the decay, rounded toward zero
   assign mag     = cur[SXX_BITS-1] ? SXX_BITS'(-cur) : SXX_BITS'(cur);
   assign prod_hi = mag[SXX_BITS-1:DECAY_BITS] * decay_coef;
   assign prod_lo = mag[DECAY_BITS-1:0] * decay_coef;
   assign r       = SXX_BITS'(prod_hi + (MAGH_BITS+DECAY_BITS)'(prod_lo[2*DECAY_BITS-1:DECAY_BITS]));
   assign dec     = cur[SXX_BITS-1] ? -$signed(ACC_BITS'(r)) : $signed(ACC_BITS'(r));
   assign acc     = dec + term;

   always_comb begin
      case (sel_ff)
         SEL_W:   acc_sat = sat_to(acc, W_BITS + 1);
         SEL_X:   acc_sat = sat_to(acc, SX_BITS);
         SEL_Y:   acc_sat = sat_to(acc, SX_BITS);
         SEL_XX:  acc_sat = sat_to(acc, SXX_BITS);
         SEL_XY:  acc_sat = sat_to(acc, SXX_BITS);
         default: acc_sat = acc;
      endcase
   end

   assign sx  = SXS_BITS'(sum_x_ff >>> HALF_E);
   assign sy  = SXS_BITS'(sum_y_ff >>> HALF_E);
   assign sxx = SXXS_BITS'(sum_xx_ff >>> E);
   assign sxy = SXXS_BITS'(sum_xy_ff >>> E);
   assign ws  = $signed({1'b0, weight_ff});

   assign det_gt = det_ff > $signed({{(NUM_BITS-CSR_BITS){1'b0}}, det_threshold});
   assign num2   = pa_ff - pb_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (!q_empty) state_in = ST_DECAY;
         ST_DECAY: if (sel_ff == SEL_XY) state_in = ST_MUL1;
         ST_MUL1:  state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_MUL3;
         ST_MUL3:  state_in = ST_MUL4;
         ST_MUL4:  state_in = det_gt ? ST_DIV : ST_OUT;
         ST_DIV:   if (div_done && div2_done) state_in = ST_OUT;
         ST_OUT:   if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop     = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE:  q_pop     = !q_empty;
         ST_MUL4:  div_start = det_gt;
         ST_OUT:   out_load  = !rsp_valid_ff || rsp_tready;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         weight_ff     <= '0;
         sum_x_ff      <= '0;
         sum_y_ff      <= '0;
         sum_xx_ff     <= '0;
         sum_xy_ff     <= '0;
         slope_hold_ff <= '0;
         icpt_hold_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DECAY) begin
            case (sel_ff)
               SEL_W:   weight_ff <= W_BITS'(acc_sat);
               SEL_X:   sum_x_ff  <= SX_BITS'(acc_sat);
               SEL_Y:   sum_y_ff  <= SX_BITS'(acc_sat);
               SEL_XX:  sum_xx_ff <= SXX_BITS'(acc_sat);
               SEL_XY:  sum_xy_ff <= SXX_BITS'(acc_sat);
               default: begin
               end
            endcase
         end
         if (state_ff == ST_DIV && div_done && div2_done) begin
            slope_hold_ff <= slope_q;
            icpt_hold_ff  <= icpt_q;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         x_ff   <= $signed(q_data[SB-1:0]);
         y_ff   <= $signed(q_data[2*SB-1:SB]);
         xx_ff  <= $signed(q_data[4*SB-1:2*SB]);
         xy_ff  <= $signed(q_data[6*SB-1:4*SB]);
         sel_ff <= SEL_W;
      end else if (state_ff == ST_DECAY) begin
         sel_ff <= sel_ff + 1'b1;
      end
      case (state_ff)
         ST_MUL1: begin
            pa_ff <= NUM_BITS'(ws * sxx);
            pb_ff <= NUM_BITS'(sx * sx);
         end
         ST_MUL2: begin
            det_ff <= pa_ff - pb_ff;
            pa_ff  <= NUM_BITS'(sxy * ws);
            pb_ff  <= NUM_BITS'(sx * sy);
         end
         ST_MUL3: begin
            num1_ff <= pa_ff - pb_ff;
            pa_ff   <= NUM_BITS'(sxx * sy);
            pb_ff   <= NUM_BITS'(sxy * sx);
         end
         ST_MUL4: fresh_ff <= det_gt;
         default: begin
         end
      endcase
      if (out_load) begin
         rsp_slope_ff <= slope_hold_ff;
         rsp_icpt_ff  <= icpt_hold_ff;
         rsp_fresh_ff <= fresh_ff;
      end
   end

   dolr_div #(.FRAC(SLOPE_SHIFT)) u_div_slope (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num1_ff),
      .den   (det_ff),
      .done  (div_done),
      .quo   (slope_q)
   );

   dolr_div #(.FRAC(ICPT_SHIFT)) u_div_icpt (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num2),
      .den   (det_ff),
      .done  (div2_done),
      .quo   (icpt_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign slope      = rsp_slope_ff;
   assign intercept  = rsp_icpt_ff;
   assign refreshed  = rsp_fresh_ff;

endmodule

### design/decayed_online_linear_regression_top.sv
// decayed online straight-line fit
// req channel: one (x, y) sample per word, signed q8.8 each, x in the low bits.
// rsp channel: one word per sample: slope in rsp_tdata[31:0], intercept in
// rsp_tdata[63:32], both signed q16.16 and saturated; rsp_tuser is high when
// the line was recomputed on this sample, else the previous line is repeated.
// csr port: index 0 writes the decay factor (unsigned q0.16), index 1 the
// determinant threshold; write only while no sample is in flight.
// a front stage takes samples into a two-word queue; the back end then works
// on one sample at a time: it fetches it, decays and updates the five running
// sums one after another through one shared scaler, runs the multiply states
// for the determinant and numerators, then starts the two 32-step dividers,
// which run side by side, and finally loads the output register.
// a sample whose line is kept skips the dividers.
// reset clears the sums, the held line, the queue and the output valid bit and
// restores the register defaults. a stalled rsp side holds the result word;
// the queue keeps taking samples until it fills.
module decayed_online_linear_regression_top
   import dolr_pkg::*;
#(
   parameter int SAMPLE_BITS         = 16,
   parameter int EXTRA_FRACTION_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // sample_x, sample_y
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // slope, intercept
   output logic [2*QUO_BITS-1:0]                  rsp_tdata,
   // refreshed
   output logic                                   rsp_tuser,
   input  logic                                   csr_wen,
   input  csr_index_type                          csr_index,
   input  logic [CSR_BITS-1:0]                    csr_wdata
);

   localparam int IN_BITS     = ((2 * SAMPLE_BITS + 7) / 8) * 8;
   localparam int ITEM_BITS   = 6 * SAMPLE_BITS;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [DECAY_BITS-1:0] DECAY_RESET  = 16'd53656;
   localparam logic [CSR_BITS-1:0]   THRESH_RESET = 16'd1;

   logic [DECAY_BITS-1:0] decay_ff;
   logic [CSR_BITS-1:0]   thresh_ff;
   logic                  q_push, q_pop, q_full, q_empty;
   logic [ITEM_BITS-1:0]  q_wdata, q_rdata;
   logic [QUO_BITS-1:0]   slope, intercept;

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff  <= DECAY_RESET;
         thresh_ff <= THRESH_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            REG_DECAY:  decay_ff  <= csr_wdata;
            REG_THRESH: thresh_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   dolr_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .IN_BITS     (IN_BITS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_wdata)
   );

   dolr_fifo #(
      .WIDTH (ITEM_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wdata),
      .pop     (q_pop),
      .rd_data (q_rdata),
      .full    (q_full),
      .empty   (q_empty)
   );

   dolr_back #(
      .SAMPLE_BITS         (SAMPLE_BITS),
      .EXTRA_FRACTION_BITS (EXTRA_FRACTION_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_data        (q_rdata),
      .q_pop         (q_pop),
      .decay_coef    (decay_ff),
      .det_threshold (thresh_ff),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .slope         (slope),
      .intercept     (intercept),
      .refreshed     (rsp_tuser)
   );

   assign rsp_tdata = {intercept, slope};

endmodule
